// ===== rtl/core/lhpe_pkg.sv =====
// Shared types and constants for the LED heat pixel emitter.
// Used by the divider cells, the output stage and the top level.
`default_nettype none

package lhpe_pkg;

  localparam int unsigned IdxW    = 12;
  localparam int unsigned DimW    = 7;
  localparam int unsigned CountW  = 13;
  localparam int unsigned PosW    = 7;
  localparam int unsigned HeatW   = 8;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned MaxCols = 64;
  localparam int unsigned MaxRows = 64;

  // Palette slope length and the two knee points.
  localparam logic [HeatW-1:0] SlopeSteps = 8'd85;
  localparam logic [HeatW-1:0] SlopeTwice = 8'd170;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_WIRING_ORDER = 2'd2,
    CFG_LED_COUNT    = 2'd3
  } cfg_reg_e;

  // Payload that travels down the divider chain.
  typedef struct packed {
    logic [DimW-1:0]  rem;       // partial remainder
    logic [IdxW-1:0]  num;       // dividend bits left, quotient bits shifted in
    logic [HeatW-1:0] heat;
    logic             in_range;  // index below the LED count
  } pipe_t;

endpackage

`default_nettype wire

// ===== rtl/core/lhpe_div_cell.sv =====
// One cell of the divider chain: a single restoring division step plus
// a pipeline register. Depends on lhpe_pkg.
`default_nettype none

module lhpe_div_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [lhpe_pkg::DimW-1:0]    divisor_i,
  input  wire                          valid_i,
  input  wire  lhpe_pkg::pipe_t        data_i,
  output logic                         ready_o,
  output logic                         valid_o,
  output lhpe_pkg::pipe_t              data_o,
  input  wire                          ready_i
);
  import lhpe_pkg::*;

  logic            valid_q;
  pipe_t           data_q;
  pipe_t           data_d;
  logic [DimW:0]   trial;
  logic            fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial  = {data_i.rem, data_i.num[IdxW-1]};
    fits   = (trial >= {1'b0, divisor_i});
    data_d = data_i;
    data_d.rem = fits ? DimW'(trial - {1'b0, divisor_i}) : trial[DimW-1:0];
    data_d.num = {data_i.num[IdxW-2:0], fits};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lhpe_out_stage.sv =====
// Output stage: turns quotient and remainder into a grid position, maps
// the heat to a fire colour and holds the result register. Uses lhpe_pkg.
`default_nettype none

module lhpe_out_stage (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  [lhpe_pkg::DimW-1:0]     grid_width_i,
  input  wire  [lhpe_pkg::DimW-1:0]     grid_height_i,
  input  wire                           wiring_order_i,
  input  wire                           valid_i,
  input  wire  lhpe_pkg::pipe_t         data_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [lhpe_pkg::PosW-1:0]     col_pos_o,
  output logic [lhpe_pkg::PosW-1:0]     row_pos_o,
  output logic [lhpe_pkg::ColorW-1:0]   red_level_o,
  output logic [lhpe_pkg::ColorW-1:0]   green_level_o,
  output logic [lhpe_pkg::ColorW-1:0]   blue_level_o
);
  import lhpe_pkg::*;

  logic              valid_q;
  logic [PosW-1:0]   col_q, row_q, col_d, row_d;
  logic [ColorW-1:0] red_q, green_q, blue_q, red_d, green_d, blue_d;
  logic [IdxW-1:0]   col_full, row_full;
  logic [DimW-1:0]   divisor;
  logic [DimW-1:0]   rem_row;
  logic              placed;
  logic [HeatW-1:0]  slope_x;
  logic [ColorW-1:0] slope_y;

  always_comb begin
    divisor = wiring_order_i ? grid_height_i : grid_width_i;
    // Serpentine wiring runs odd columns bottom to top.
    rem_row = data_i.num[0] ? DimW'(grid_height_i - 1'b1 - data_i.rem) : data_i.rem;
    if (wiring_order_i) begin
      col_full = data_i.num;
      row_full = {{(IdxW-DimW){1'b0}}, rem_row};
    end else begin
      col_full = {{(IdxW-DimW){1'b0}}, data_i.rem};
      row_full = data_i.num;
    end
    placed = data_i.in_range && (divisor != '0)
          && (col_full < {{(IdxW-DimW){1'b0}}, grid_width_i})
          && (row_full < {{(IdxW-DimW){1'b0}}, grid_height_i})
          && (col_full < IdxW'(MaxCols))
          && (row_full < IdxW'(MaxRows));
    col_d = placed ? col_full[PosW-1:0] : '1;
    row_d = placed ? row_full[PosW-1:0] : '1;
  end

  // Three palette slopes of three steps per heat unit.
  always_comb begin
    if (data_i.heat < SlopeSteps) begin
      slope_x = data_i.heat;
    end else if (data_i.heat < SlopeTwice) begin
      slope_x = data_i.heat - SlopeSteps;
    end else begin
      slope_x = data_i.heat - SlopeTwice;
    end
    slope_y = ColorW'({slope_x, 1'b0} + {1'b0, slope_x});
    if (data_i.heat < SlopeSteps) begin
      red_d   = slope_y;
      green_d = '0;
      blue_d  = '0;
    end else if (data_i.heat < SlopeTwice) begin
      red_d   = '1;
      green_d = slope_y;
      blue_d  = '0;
    end else begin
      red_d   = '1;
      green_d = '1;
      blue_d  = slope_y;
    end
  end

  assign ready_o       = !valid_q || !out_stall_i;
  assign out_valid_o   = valid_q;
  assign col_pos_o     = col_q;
  assign row_pos_o     = row_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/led_heat_pixel_emitter.sv =====
// LED heat pixel emitter: maps a strip index and heat value to a grid
// position and a fire colour. Built from lhpe_div_cell, lhpe_out_stage
// and the types in lhpe_pkg.
//
// Input channel: led_index_i and heat_level_i, transfer when in_valid_i
// is high and in_stall_o is low. Output channel: col_pos_o, row_pos_o and
// the three colour levels, transfer when out_valid_o is high and
// out_stall_i is low. Configuration writes go through cfg_valid_i,
// cfg_index_i and cfg_data_i; cfg_ready_o is always high, and the grid
// registers should only change while no item is in flight.
//
// The index is divided by the grid width (row-major) or the grid height
// (serpentine columns) in a chain of 12 cells, one quotient bit per cell.
// An item passes 13 registers, 12 divider cells plus the output register,
// and out_valid_o is driven from the output register. Throughput is one
// item per cycle while out_stall_i is low.
// When out_stall_i is held the output register keeps its result and the
// chain fills up; in_stall_o rises only once every cell holds an item.
// Reset empties the chain and loads a 16 by 16 row-major grid of 256 LEDs.
`default_nettype none

module led_heat_pixel_emitter (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [lhpe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [lhpe_pkg::CountW-1:0]    cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [lhpe_pkg::IdxW-1:0]      led_index_i,
  input  wire  [lhpe_pkg::HeatW-1:0]     heat_level_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [lhpe_pkg::PosW-1:0]      col_pos_o,
  output logic [lhpe_pkg::PosW-1:0]      row_pos_o,
  output logic [lhpe_pkg::ColorW-1:0]    red_level_o,
  output logic [lhpe_pkg::ColorW-1:0]    green_level_o,
  output logic [lhpe_pkg::ColorW-1:0]    blue_level_o
);
  import lhpe_pkg::*;

  logic [DimW-1:0]   grid_width_q;
  logic [DimW-1:0]   grid_height_q;
  logic              wiring_order_q;
  logic [CountW-1:0] led_count_q;
  logic [DimW-1:0]   divisor;

  logic              cell_valid [IdxW+1];
  pipe_t             cell_data  [IdxW+1];
  logic              cell_ready [IdxW+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= DimW'(16);
      grid_height_q  <= DimW'(16);
      wiring_order_q <= 1'b0;
      led_count_q    <= CountW'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_GRID_WIDTH:   grid_width_q   <= cfg_data_i[DimW-1:0];
        CFG_GRID_HEIGHT:  grid_height_q  <= cfg_data_i[DimW-1:0];
        CFG_WIRING_ORDER: wiring_order_q <= cfg_data_i[0];
        CFG_LED_COUNT:    led_count_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign divisor = wiring_order_q ? grid_height_q : grid_width_q;

  always_comb begin
    cell_valid[0]         = in_valid_i;
    cell_data[0].rem      = '0;
    cell_data[0].num      = led_index_i;
    cell_data[0].heat     = heat_level_i;
    cell_data[0].in_range = ({1'b0, led_index_i} < led_count_q);
  end

  assign in_stall_o = !cell_ready[0];

  for (genvar k = 0; k < IdxW; k++) begin : g_cell
    lhpe_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (divisor),
      .valid_i   (cell_valid[k]),
      .data_i    (cell_data[k]),
      .ready_o   (cell_ready[k]),
      .valid_o   (cell_valid[k+1]),
      .data_o    (cell_data[k+1]),
      .ready_i   (cell_ready[k+1])
    );
  end

  lhpe_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grid_width_i   (grid_width_q),
    .grid_height_i  (grid_height_q),
    .wiring_order_i (wiring_order_q),
    .valid_i        (cell_valid[IdxW]),
    .data_i         (cell_data[IdxW]),
    .ready_o        (cell_ready[IdxW]),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .col_pos_o      (col_pos_o),
    .row_pos_o      (row_pos_o),
    .red_level_o    (red_level_o),
    .green_level_o  (green_level_o),
    .blue_level_o   (blue_level_o)
  );

endmodule

`default_nettype wire
